>>> src/tcvd_pkg.sv
`default_nettype none
package tcvd_pkg;

  localparam int TABLE_SIZE = 4096;
  localparam int IDX_W = $clog2(TABLE_SIZE);
  localparam int CNT_W = IDX_W + 1;
  localparam int OUT_IDX_W = 12;

  localparam logic [2:0] REG_MIN_X = 3'd0;
  localparam logic [2:0] REG_MIN_Y = 3'd1;
  localparam logic [2:0] REG_MIN_Z = 3'd2;
  localparam logic [2:0] REG_MAX_X = 3'd3;
  localparam logic [2:0] REG_MAX_Y = 3'd4;
  localparam logic [2:0] REG_MAX_Z = 3'd5;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_SCAN,
    ST_DECIDE,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic        wr;
    logic [IDX_W-1:0] wr_addr;
    logic [95:0] wr_data;
    logic [IDX_W-1:0] rd_addr;
  } mem_ctl_t;

  // ieee ordered a <= b, false on nan
  function automatic logic fp_le(input logic [31:0] a, input logic [31:0] b);
    logic a_nan;
    logic b_nan;
    logic a_zero;
    logic b_zero;
    logic r;
    a_nan = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
    b_nan = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
    a_zero = (a[30:0] == 31'd0);
    b_zero = (b[30:0] == 31'd0);
    if (a_nan || b_nan) begin
      r = 1'b0;
    end else if (a_zero && b_zero) begin
      r = 1'b1;
    end else if (a[31] != b[31]) begin
      r = a[31];
    end else if (!a[31]) begin
      r = (a[30:0] <= b[30:0]);
    end else begin
      r = (a[30:0] >= b[30:0]);
    end
    return r;
  endfunction

  // ieee equality, +0 == -0, nan never equal
  function automatic logic fp_eq(input logic [31:0] a, input logic [31:0] b);
    logic a_nan;
    logic r;
    a_nan = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
    if (a_nan) begin
      r = 1'b0;
    end else if ((a[30:0] == 31'd0) && (b[30:0] == 31'd0)) begin
      r = 1'b1;
    end else begin
      r = (a == b);
    end
    return r;
  endfunction

endpackage
`default_nettype wire

>>> src/triangle_clip_vertex_dedup.sv
`default_nettype none
// a dropped triangle goes from SETUP straight to DONE and then the done strobe;
// a kept one passes, per vertex, through SCAN and DECIDE before DONE
// the scan reads one stored vertex per cycle and stops early on a match
// one triangle at a time: start is taken only in IDLE; busy is high until the done strobe
// the receiver cannot stall; done is high for exactly one cycle per transaction
// reset clears the vertex count and sets the box to the whole space
module triangle_clip_vertex_dedup
  import tcvd_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_data,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [31:0] vert_a_x,
  input  wire logic [31:0] vert_a_y,
  input  wire logic [31:0] vert_a_z,
  input  wire logic [31:0] vert_b_x,
  input  wire logic [31:0] vert_b_y,
  input  wire logic [31:0] vert_b_z,
  input  wire logic [31:0] vert_c_x,
  input  wire logic [31:0] vert_c_y,
  input  wire logic [31:0] vert_c_z,
  output logic             done,
  output logic             kept,
  output logic [11:0]      index_a,
  output logic [11:0]      index_b,
  output logic [11:0]      index_c,
  output logic             fresh_a,
  output logic             fresh_b,
  output logic             fresh_c,
  output logic             overflow
);

  state_t state, state_next;
  logic [95:0] verts [3];
  logic [1:0] vsel;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] ptr;
  logic rd_valid;
  logic [IDX_W-1:0] rd_idx;
  logic keep_r;
  logic found;
  logic [IDX_W-1:0] found_idx;
  logic [IDX_W-1:0] idx_r [3];
  logic [2:0] fresh_r;
  logic ovf_r;
  logic in_a, in_b, in_c;
  logic [95:0] rd_data;
  logic [95:0] cur;
  logic hit;
  mem_ctl_t ctl;

  tcvd_box u_box_a (.clk, .rst, .cfg_we, .cfg_index, .cfg_data,
    .vert({vert_a_x, vert_a_y, vert_a_z}), .enclosed(in_a));
  tcvd_box u_box_b (.clk, .rst, .cfg_we, .cfg_index, .cfg_data,
    .vert({vert_b_x, vert_b_y, vert_b_z}), .enclosed(in_b));
  tcvd_box u_box_c (.clk, .rst, .cfg_we, .cfg_index, .cfg_data,
    .vert({vert_c_x, vert_c_y, vert_c_z}), .enclosed(in_c));

  tcvd_table u_table (.clk, .ctl, .rd_data);

  assign cur = verts[vsel];
  assign hit = rd_valid && fp_eq(cur[95:64], rd_data[95:64]) &&
               fp_eq(cur[63:32], rd_data[63:32]) && fp_eq(cur[31:0], rd_data[31:0]);
  assign busy = (state != ST_IDLE);

  always_comb begin
    state_next = state;
    ctl.wr = 1'b0;
    ctl.wr_addr = count[IDX_W-1:0];
    ctl.wr_data = cur;
    ctl.rd_addr = ptr[IDX_W-1:0];
    case (state)
      ST_IDLE: if (start) state_next = ST_SETUP;
      ST_SETUP: state_next = keep_r ? ST_SCAN : ST_DONE;
      ST_SCAN: if (hit || (!found && ptr == count && !rd_valid)) state_next = ST_DECIDE;
        else if (ptr == count && rd_valid && !hit) state_next = ST_DECIDE;
      ST_DECIDE: begin
        if (!found && count != CNT_W'(TABLE_SIZE)) ctl.wr = 1'b1;
        state_next = (vsel == 2'd2) ? ST_DONE : ST_SCAN;
      end
      ST_DONE: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
      done <= 1'b0;
    end else begin
      state <= state_next;
      done <= (state == ST_DONE);
      if (state == ST_DECIDE && ctl.wr) count <= count + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: if (start) begin
        verts[0] <= {vert_a_x, vert_a_y, vert_a_z};
        verts[1] <= {vert_b_x, vert_b_y, vert_b_z};
        verts[2] <= {vert_c_x, vert_c_y, vert_c_z};
        keep_r <= in_a || in_b || in_c;
        vsel <= 2'd0;
        ptr <= '0;
        rd_valid <= 1'b0;
        found <= 1'b0;
        fresh_r <= '0;
        ovf_r <= 1'b0;
        idx_r[0] <= '0;
        idx_r[1] <= '0;
        idx_r[2] <= '0;
      end
      ST_SCAN: begin
        if (hit) begin
          found <= 1'b1;
          found_idx <= rd_idx;
          rd_valid <= 1'b0;
        end else if (ptr != count) begin
          rd_valid <= 1'b1;
          rd_idx <= ptr[IDX_W-1:0];
          ptr <= ptr + 1'b1;
        end else begin
          rd_valid <= 1'b0;
        end
      end
      ST_DECIDE: begin
        if (found) begin
          idx_r[vsel] <= found_idx;
        end else if (count != CNT_W'(TABLE_SIZE)) begin
          idx_r[vsel] <= count[IDX_W-1:0];
          fresh_r[vsel] <= 1'b1;
        end else begin
          idx_r[vsel] <= '0;
          ovf_r <= 1'b1;
        end
        vsel <= vsel + 1'b1;
        ptr <= '0;
        rd_valid <= 1'b0;
        found <= 1'b0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (state == ST_DONE) begin
      kept <= keep_r;
      index_a <= OUT_IDX_W'(idx_r[0]);
      index_b <= OUT_IDX_W'(idx_r[1]);
      index_c <= OUT_IDX_W'(idx_r[2]);
      fresh_a <= fresh_r[0];
      fresh_b <= fresh_r[1];
      fresh_c <= fresh_r[2];
      overflow <= ovf_r;
    end
  end

endmodule
`default_nettype wire

>>> src/tcvd_table.sv
`default_nettype none
module tcvd_table
  import tcvd_pkg::*;
(
  input  wire logic     clk,
  input  wire mem_ctl_t ctl,
  output logic [95:0]   rd_data
);

  logic [95:0] mem [TABLE_SIZE];

  always_ff @(posedge clk) begin
    if (ctl.wr) begin
      mem[ctl.wr_addr] <= ctl.wr_data;
    end
    rd_data <= mem[ctl.rd_addr];
  end

endmodule
`default_nettype wire

>>> src/tcvd_box.sv
`default_nettype none
module tcvd_box
  import tcvd_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_data,
  input  wire logic [95:0] vert,
  output logic             enclosed
);

  logic [31:0] min_x, min_y, min_z, max_x, max_y, max_z;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_x <= 32'hFF80_0000;
      min_y <= 32'hFF80_0000;
      min_z <= 32'hFF80_0000;
      max_x <= 32'h7F80_0000;
      max_y <= 32'h7F80_0000;
      max_z <= 32'h7F80_0000;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MIN_X: min_x <= cfg_data;
        REG_MIN_Y: min_y <= cfg_data;
        REG_MIN_Z: min_z <= cfg_data;
        REG_MAX_X: max_x <= cfg_data;
        REG_MAX_Y: max_y <= cfg_data;
        REG_MAX_Z: max_z <= cfg_data;
        default: ;
      endcase
    end
  end

  assign enclosed = fp_le(min_x, vert[95:64]) && fp_le(vert[95:64], max_x) &&
                    fp_le(min_y, vert[63:32]) && fp_le(vert[63:32], max_y) &&
                    fp_le(min_z, vert[31:0]) && fp_le(vert[31:0], max_z);

endmodule
`default_nettype wire
